/* sv/free_list_slot_allocator_macros.svh */
// assertion macros used by the checker file
`ifndef FREE_LIST_SLOT_ALLOCATOR_MACROS_SVH
`define FREE_LIST_SLOT_ALLOCATOR_MACROS_SVH

// generic clocked assertion with an active-low reset
`define FLS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("free list allocator assertion failed");

// assertion on the default clock and reset names
`define FLS_ASSERT_DEF(label, prop) \
  `FLS_ASSERT(label, clk_i, rst_ni, prop)

`endif

/* sv/fls_pkg.sv */
// shared constants, codes and types of the free list slot allocator
package fls_pkg;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = SlotW + 1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2
  } status_e;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    logic [SlotW-1:0] data;
  } push_t;

endpackage

/* sv/fls_if.sv */
// request and response channel interfaces of the free list slot allocator
interface fls_req_if;
  logic          valid;
  logic          ready;
  fls_pkg::op_e  operation;
  logic [7:0]    slot_index;

  modport source (output valid, output operation, output slot_index, input ready);
  modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface fls_rsp_if;
  logic              valid;
  logic              ready;
  logic [7:0]        granted_slot;
  fls_pkg::status_e  status;
  logic [8:0]        used_slots;
  logic [8:0]        high_water;

  modport source (output valid, output granted_slot, output status, output used_slots,
                  output high_water, input ready);
  modport sink   (input valid, input granted_slot, input status, input used_slots,
                  input high_water, output ready);
endinterface

/* sv/free_list_slot_allocator.sv */
// free list slot allocator: one request word in, one response word out per request
// the response passes through the input register and then the result register
// throughput: one request per cycle, back to back, when the response side keeps ready high
// the next free id is prefetched from the stack memory by a registered read with write forwarding
// reset: all slots free, stack holds ids in order, used and high-water counts zero
module free_list_slot_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  fls_req_if.sink   req_i,
  fls_rsp_if.source rsp_o
);
  import fls_pkg::*;

  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);

  // input register
  logic             in_valid_q;
  op_e              op_q;
  logic [7:0]       idx_q;

  // state
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  peak_q, peak_d;
  logic [SLOTS-1:0] active_q, active_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       granted_q, granted_d;
  status_e          status_q, status_d;

  logic             fire;
  logic             in_range;
  logic [SlotW-1:0] top;
  push_t            push;

  assign fire        = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || fire;
  assign in_range    = {1'b0, idx_q} < SlotsCnt;

  fls_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rd_addr_i (used_d[SlotW-1:0]),
    .top_o     (top)
  );

  always_comb begin
    used_d    = used_q;
    peak_d    = peak_q;
    active_d  = active_q;
    granted_d = granted_q;
    status_d  = status_q;
    push.en   = 1'b0;
    push.addr = used_q[SlotW-1:0] - SlotW'(1);
    push.data = idx_q[SlotW-1:0];
    if (fire) begin
      granted_d = '0;
      case (op_q)
        OP_ALLOC: begin
          if (used_q == SlotsCnt) begin
            status_d = ST_FULL;
          end else begin
            status_d       = ST_OK;
            granted_d      = 8'(top);
            active_d[top]  = 1'b1;
            used_d         = used_q + CntW'(1);
            if (used_d > peak_q) begin
              peak_d = peak_q + CntW'(1);
            end
          end
        end
        OP_RELEASE: begin
          if (!in_range || !active_q[idx_q[SlotW-1:0]] || used_q == '0) begin
            status_d = ST_BAD_ID;
          end else begin
            status_d                     = ST_OK;
            active_d[idx_q[SlotW-1:0]]   = 1'b0;
            used_d                       = used_q - CntW'(1);
            push.en                      = 1'b1;
          end
        end
        default: begin
          status_d = ST_BAD_ID;
        end
      endcase
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready) begin
      op_q  <= req_i.operation;
      idx_q <= req_i.slot_index;
    end
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      peak_q      <= '0;
      active_q    <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      peak_q      <= peak_d;
      active_q    <= active_d;
    end
  end

  // counts are registered state and hold between responses
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_slot = granted_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.used_slots   = 9'(used_q);
  assign rsp_o.high_water   = 9'(peak_q);

endmodule

/* sv/fls_stack.sv */
// free id stack: memory plus written-entry flags, registered top-of-stack read
module fls_stack (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fls_pkg::push_t           push_i,
  input  logic [fls_pkg::SlotW-1:0] rd_addr_i,
  output logic [fls_pkg::SlotW-1:0] top_o
);
  import fls_pkg::*;

  logic [SlotW-1:0] mem [SLOTS];
  logic [SLOTS-1:0] written_q;
  logic [SlotW-1:0] mem_rd_q;
  logic [SlotW-1:0] rd_addr_q;
  logic             written_rd_q;
  logic             fwd_q;
  logic [SlotW-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (push_i.en) begin
      mem[push_i.addr] <= push_i.data;
    end
    mem_rd_q   <= mem[rd_addr_i];
    fwd_data_q <= push_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_addr_q    <= '0;
      written_rd_q <= 1'b0;
      fwd_q        <= 1'b0;
    end else begin
      if (push_i.en) begin
        written_q[push_i.addr] <= 1'b1;
      end
      rd_addr_q    <= rd_addr_i;
      written_rd_q <= written_q[rd_addr_i];
      fwd_q        <= push_i.en && (push_i.addr == rd_addr_i);
    end
  end

  // an entry never pushed still holds its reset id, which equals its position
  always_comb begin
    if (fwd_q) begin
      top_o = fwd_data_q;
    end else if (written_rd_q) begin
      top_o = mem_rd_q;
    end else begin
      top_o = rd_addr_q;
    end
  end

endmodule

/* sv/fls_checker.sv */
// port-level checks of the free list slot allocator, bound to the top level
`include "free_list_slot_allocator_macros.svh"

module fls_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [7:0]       granted_slot_i,
  input fls_pkg::status_e status_i,
  input logic [8:0]       used_slots_i,
  input logic [8:0]       high_water_i
);
  import fls_pkg::*;

  `FLS_ASSERT_DEF(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(granted_slot_i) && $stable(status_i)))
  `FLS_ASSERT_DEF(a_peak_covers_used, rsp_valid_i |-> (high_water_i >= used_slots_i))
  `FLS_ASSERT_DEF(a_peak_monotonic, (rsp_valid_i && $past(rsp_valid_i)) |-> (high_water_i >= $past(high_water_i)))
  `FLS_ASSERT_DEF(a_error_no_grant, (rsp_valid_i && status_i != ST_OK) |-> (granted_slot_i == 8'd0))

endmodule

bind free_list_slot_allocator fls_checker u_fls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .granted_slot_i (rsp_o.granted_slot),
  .status_i       (rsp_o.status),
  .used_slots_i   (rsp_o.used_slots),
  .high_water_i   (rsp_o.high_water)
);

/* bench/tb_free_list_slot_allocator.sv */
// self-checking testbench of the free list slot allocator
module tb_free_list_slot_allocator;
  import fls_pkg::*;

  typedef struct packed {
    logic [7:0] granted;
    status_e    status;
    logic [8:0] used;
    logic [8:0] peak;
  } grant_word_t;

  typedef struct {
    op_e         op;
    logic [7:0]  idx;
    bit          typed;
    grant_word_t want;
  } stim_row_t;

  localparam int NumRows = 14;

  logic clk_i = 1'b0;
  logic rst_ni;

  fls_req_if req ();
  fls_rsp_if rsp ();

  free_list_slot_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: free id stack, busy bit per slot, counts
  logic [SlotW-1:0] pred_stack [SLOTS];
  bit               slot_busy [SLOTS];
  logic [CntW-1:0]  used_cnt;
  logic [CntW-1:0]  peak_cnt;

  grant_word_t pending_grants [$];
  int          mismatch_count = 0;

  // typed expectation of the word now being offered, set at the falling edge
  bit          row_typed = 1'b0;
  grant_word_t row_want  = '0;

  bit hold_rsp  = 1'b0;
  bit calm_tail = 1'b0;
  bit gaps_on   = 1'b1;

  function automatic grant_word_t predict_grant(op_e op, logic [7:0] idx);
    grant_word_t      res;
    logic [SlotW-1:0] id;
    res = '0;
    if (op == OP_ALLOC) begin
      if (used_cnt >= CntW'(SLOTS)) begin
        res.status = ST_FULL;
      end else begin
        id = pred_stack[used_cnt[SlotW-1:0]];
        used_cnt = used_cnt + 1'b1;
        slot_busy[id] = 1'b1;
        if (used_cnt > peak_cnt) peak_cnt = peak_cnt + 1'b1;
        res.granted = 8'(id);
        res.status  = ST_OK;
      end
    end else if (32'(idx) >= SLOTS || !slot_busy[idx] || used_cnt == '0) begin
      res.status = ST_BAD_ID;
    end else begin
      slot_busy[idx] = 1'b0;
      used_cnt = used_cnt - 1'b1;
      pred_stack[used_cnt[SlotW-1:0]] = SlotW'(idx);
      res.status = ST_OK;
    end
    res.used = used_cnt;
    res.peak = peak_cnt;
    return res;
  endfunction

  // response check first: the word leaving is always older than the one entering
  always @(posedge clk_i or negedge rst_ni) begin
    grant_word_t got;
    grant_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        pred_stack[i] = SlotW'(i);
        slot_busy[i]  = 1'b0;
      end
      used_cnt = '0;
      peak_cnt = '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.granted_slot, rsp.status, rsp.used_slots, rsp.high_water};
        if (pending_grants.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response word: slot %0d status %0d used %0d peak %0d",
                     got.granted, got.status, got.used, got.peak);
        end else begin
          want = pending_grants.pop_front();
          if (got.granted !== want.granted || got.status !== want.status ||
              got.used !== want.used || got.peak !== want.peak) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: want slot %0d status %0d used %0d peak %0d, %s",
                       want.granted, want.status, want.used, want.peak,
                       $sformatf("got slot %0d status %0d used %0d peak %0d",
                                 got.granted, got.status, got.used, got.peak));
          end
        end
      end
      if (req.valid && req.ready) begin
        want = predict_grant(req.operation, req.slot_index);
        pending_grants.push_back(row_typed ? row_want : want);
      end
    end
  end

  // response side: random stall bursts, one long hold-off on request
  initial begin
    int  n;
    bit  stalls_on;
    stalls_on = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (199) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else if (!calm_tail && stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        rsp.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) stalls_on = !stalls_on;
    end
  end

  task automatic drive_request(op_e op, logic [7:0] idx, bit typed, grant_word_t want);
    @(negedge clk_i);
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.slot_index <= idx;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic sender_gap();
    int n;
    if (gaps_on && !calm_tail && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      @(negedge clk_i);
      req.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed: releases pick a busy slot, one in ten is a random id
  task automatic send_random(int alloc_pct);
    logic [7:0] idx;
    op_e        op;
    int         start;
    idx = 8'($urandom);
    if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
    if ($urandom_range(0, 99) < alloc_pct) begin
      op = OP_ALLOC;
    end else begin
      op = OP_RELEASE;
      if (used_cnt != '0 && $urandom_range(0, 9) != 0) begin
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_busy[(start + k) % SLOTS]) begin
            idx = 8'((start + k) % SLOTS);
            break;
          end
        end
      end
    end
    sender_gap();
    drive_request(op, idx, 1'b0, '0);
  endtask

  task automatic fill_table();
    while (used_cnt != CntW'(SLOTS)) send_random(85);
    repeat (3) send_random(100);
  endtask

  task automatic drain_table();
    while (used_cnt != '0) send_random(15);
    repeat (2) send_random(0);
  endtask

  initial begin
    stim_row_t directed_rows [NumRows];
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.operation  = OP_ALLOC;
    req.slot_index = '0;
    rsp.ready      = 1'b0;

    directed_rows[0]  = '{OP_RELEASE, 8'd0,   1'b1, '{8'd0, ST_BAD_ID, 9'd0, 9'd0}};
    directed_rows[1]  = '{OP_RELEASE, 8'd255, 1'b1, '{8'd0, ST_BAD_ID, 9'd0, 9'd0}};
    directed_rows[2]  = '{OP_ALLOC,   8'd255, 1'b1, '{8'd0, ST_OK,     9'd1, 9'd1}};
    directed_rows[3]  = '{OP_ALLOC,   8'd0,   1'b1, '{8'd1, ST_OK,     9'd2, 9'd2}};
    directed_rows[4]  = '{OP_ALLOC,   8'hAA,  1'b1, '{8'd2, ST_OK,     9'd3, 9'd3}};
    directed_rows[5]  = '{OP_RELEASE, 8'd1,   1'b1, '{8'd0, ST_OK,     9'd2, 9'd3}};
    directed_rows[6]  = '{OP_RELEASE, 8'd1,   1'b1, '{8'd0, ST_BAD_ID, 9'd2, 9'd3}};
    // the released id comes back first
    directed_rows[7]  = '{OP_ALLOC,   8'h55,  1'b0, '0};
    directed_rows[8]  = '{OP_RELEASE, 8'd0,   1'b0, '0};
    directed_rows[9]  = '{OP_RELEASE, 8'd2,   1'b0, '0};
    directed_rows[10] = '{OP_RELEASE, 8'd1,   1'b0, '0};
    // release with nothing in use
    directed_rows[11] = '{OP_RELEASE, 8'd1,   1'b0, '0};
    directed_rows[12] = '{OP_ALLOC,   8'hFF,  1'b0, '0};
    directed_rows[13] = '{OP_RELEASE, 8'd128, 1'b0, '0};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      drive_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].typed,
                    directed_rows[i].want);
    wait_results_drained();

    // long response hold-off while requests keep coming
    hold_rsp = 1'b1;
    fill_table();
    wait_results_drained();
    drain_table();
    repeat (200) send_random(50);
    fill_table();
    wait_results_drained();

    calm_tail = 1'b1;
    repeat (80) send_random(30);
    repeat (80) send_random(70);

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_free_list_slot_allocator: done, clean");
    end else begin
      $display("tb_free_list_slot_allocator: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_free_list_slot_allocator: done, errors");
    $finish;
  end

endmodule
